[hw/rtl/vgmd_pkg.sv]
// ----------------------------------------------------------------------------
// vgmd_pkg - shared types and constants for the voxel group mode downsampler
// Voxel type, per-group count type and the group constants.
// ----------------------------------------------------------------------------
package vgmd_pkg;

    // Voxels in one 2x2x2 group
    localparam int GROUP_SIZE = 8;
    // Air wins only when more than this many voxels are air
    localparam int AIR_LIMIT  = 4;
    // Count width: must hold GROUP_SIZE itself
    localparam int CNT_W      = $clog2(GROUP_SIZE + 1);

    typedef logic [7:0]       voxel_t;
    typedef logic [CNT_W-1:0] count_t;

    // Type zero is air
    localparam voxel_t AIR_TYPE = 8'd0;

endpackage

[hw/rtl/voxel_group_mode_downsample.sv]
// ----------------------------------------------------------------------------
// voxel_group_mode_downsample - 2x2x2 mode filter for level-of-detail voxels
// Takes eight voxel types of a group in z-order and returns the most frequent
// non-zero type; ties go to the type that reached the top count first, and
// air is returned only when more than four voxels are air.
//
// The block accepts one group per clock while the output side does not stall
// and delivers one result per group. It is a four-stage pipeline: pairwise
// type compares, running counts and air count, then the winner scan split
// over two stages (positions 0-3, then 4-7 with the air override).
// Backpressure on the output freezes the stages from the back; empty stages
// keep filling, so no beat is lost.
// ----------------------------------------------------------------------------
module voxel_group_mode_downsample
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  vgmd_pkg::voxel_t voxel_0,
    input  vgmd_pkg::voxel_t voxel_1,
    input  vgmd_pkg::voxel_t voxel_2,
    input  vgmd_pkg::voxel_t voxel_3,
    input  vgmd_pkg::voxel_t voxel_4,
    input  vgmd_pkg::voxel_t voxel_5,
    input  vgmd_pkg::voxel_t voxel_6,
    input  vgmd_pkg::voxel_t voxel_7,
    output logic             out_valid,
    input  logic             out_ready,
    output vgmd_pkg::voxel_t lod_type
);
    import vgmd_pkg::*;

    localparam int HALF = GROUP_SIZE / 2;

    // Stage enables
    logic en1, en2, en3, en4;

    // Input beat as an array
    voxel_t in_vox [GROUP_SIZE];

    // Stage 1: voxels and pairwise equality (row k, columns below k)
    logic                  s1_valid_reg;
    voxel_t                s1_vox_reg  [GROUP_SIZE];
    logic [GROUP_SIZE-1:0] s1_eq_reg   [GROUP_SIZE];
    logic [GROUP_SIZE-1:0] s1_eq_next  [GROUP_SIZE];

    // Stage 2: running counts and air count
    logic   s2_valid_reg;
    voxel_t s2_vox_reg  [GROUP_SIZE];
    count_t s2_run_reg  [GROUP_SIZE];
    count_t s2_run_next [GROUP_SIZE];
    count_t s2_air_reg;
    count_t s2_air_next;

    // Stage 3: scan over the first half
    logic   s3_valid_reg;
    voxel_t s3_vox_reg [HALF];
    count_t s3_run_reg [HALF];
    count_t s3_air_reg;
    count_t s3_best_cnt_reg;
    count_t s3_best_cnt_next;
    voxel_t s3_best_type_reg;
    voxel_t s3_best_type_next;

    // Stage 4: output register
    logic   s4_valid_reg;
    voxel_t s4_type_reg;
    voxel_t s4_type_next;

    assign in_vox[0] = voxel_0;
    assign in_vox[1] = voxel_1;
    assign in_vox[2] = voxel_2;
    assign in_vox[3] = voxel_3;
    assign in_vox[4] = voxel_4;
    assign in_vox[5] = voxel_5;
    assign in_vox[6] = voxel_6;
    assign in_vox[7] = voxel_7;

    // Pipeline flow control: a stage moves when it is empty or its
    // successor moves
    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    assign out_valid = s4_valid_reg;
    assign lod_type  = s4_type_reg;

    // Stage 1 compare matrix
    always_comb
    begin
        for (int k = 0; k < GROUP_SIZE; k++)
        begin
            s1_eq_next[k] = '0;
            for (int m = 0; m < k; m++)
            begin
                s1_eq_next[k][m] = (in_vox[m] == in_vox[k]);
            end
        end
    end

    // Stage 2 running counts: the voxel itself plus earlier matches
    always_comb
    begin
        s2_air_next = '0;
        for (int k = 0; k < GROUP_SIZE; k++)
        begin
            s2_run_next[k] = count_t'(1);
            for (int m = 0; m < GROUP_SIZE; m++)
            begin
                s2_run_next[k] = s2_run_next[k] + count_t'(s1_eq_reg[k][m]);
            end
            s2_air_next = s2_air_next + count_t'(s1_vox_reg[k] == AIR_TYPE);
        end
    end

    // Stage 3 scan, positions 0 to HALF-1
    always_comb
    begin
        s3_best_cnt_next  = '0;
        s3_best_type_next = AIR_TYPE;
        for (int k = 0; k < HALF; k++)
        begin
            if (s2_vox_reg[k] != AIR_TYPE && s2_run_reg[k] > s3_best_cnt_next)
            begin
                s3_best_cnt_next  = s2_run_reg[k];
                s3_best_type_next = s2_vox_reg[k];
            end
        end
    end

    // Stage 4 scan, positions HALF to GROUP_SIZE-1, then air override
    always_comb
    begin
        count_t best_cnt;
        best_cnt     = s3_best_cnt_reg;
        s4_type_next = s3_best_type_reg;
        for (int k = 0; k < HALF; k++)
        begin
            if (s3_vox_reg[k] != AIR_TYPE && s3_run_reg[k] > best_cnt)
            begin
                best_cnt     = s3_run_reg[k];
                s4_type_next = s3_vox_reg[k];
            end
        end
        if (s3_air_reg > count_t'(AIR_LIMIT))
        begin
            s4_type_next = AIR_TYPE;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers, loaded only with a live beat
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_vox_reg <= in_vox;
            s1_eq_reg  <= s1_eq_next;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_vox_reg <= s1_vox_reg;
            s2_run_reg <= s2_run_next;
            s2_air_reg <= s2_air_next;
        end
        if (en3 && s2_valid_reg)
        begin
            for (int k = 0; k < HALF; k++)
            begin
                s3_vox_reg[k] <= s2_vox_reg[k + HALF];
                s3_run_reg[k] <= s2_run_reg[k + HALF];
            end
            s3_air_reg       <= s2_air_reg;
            s3_best_cnt_reg  <= s3_best_cnt_next;
            s3_best_type_reg <= s3_best_type_next;
        end
        if (en4 && s3_valid_reg)
        begin
            s4_type_reg <= s4_type_next;
        end
    end

endmodule
